// ----- rtl/core/t2i_pkg.sv -----
package t2i_pkg;

	// parser phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SKIP   = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_HEXPFX = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UA_OFS = 8'h37;  // 'A' - 10
	localparam logic [7:0] CH_LA_OFS = 8'h57;  // 'a' - 10

	localparam logic [6:0] DIGIT_NONE = 7'd64;

	localparam logic [5:0] BASE_AUTO = 6'd0;
	localparam logic [5:0] BASE_OCT  = 6'd8;
	localparam logic [5:0] BASE_DEC  = 6'd10;
	localparam logic [5:0] BASE_HEX  = 6'd16;

	// magnitude limits for positive and negative results
	localparam logic [31:0] MAG_POS_LIMIT = 32'h7fff_ffff;
	localparam logic [31:0] MAG_NEG_LIMIT = 32'h8000_0000;

	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [7:0] r;
		r = {1'b0, DIGIT_NONE};
		if (c >= CH_ZERO && c <= CH_NINE)
			r = c - CH_ZERO;
		else if (c >= CH_UA && c <= CH_UZ)
			r = c - CH_UA_OFS;
		else if (c >= CH_LA && c <= CH_LZ)
			r = c - CH_LA_OFS;
		return r[6:0];
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ----- rtl/core/text_to_int32_parser_core.sv -----
// channel | dir | handshake            | payload
// --------+-----+----------------------+------------------------------------------
// in      | in  | in_valid / in_stall  | ch, start_req
// out     | out | out_valid / out_stall| value, range_error, converted, end_offset
// cfg     | in  | cfg_we               | cfg_wdata (number base)
//
// One character per cycle unless a stalled result holds the input: an input
// register feeds one step of the parser (one 32x6 multiply-add with a limit
// compare) into the result register, which takes the terminating character's result.
// arst_n clears the handshake state, the phase and the base register.
// in_stall rises only while a character waits in the input register and the
// result register holds an untaken result.
module text_to_int32_parser_core #(
	parameter int POSITION_LIMIT = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         ch,
	input  logic               start_req,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic               range_error,
	output logic               converted,
	output logic [15:0]        end_offset
);
	import t2i_pkg::*;

	localparam int PW = $clog2(POSITION_LIMIT + 1);

	logic [5:0]    base_cfg_q;
	logic          valid_s1;
	logic [7:0]    ch_s1;
	logic          start_s1;

	logic [2:0]    phase_q;
	logic          neg_q;
	logic [5:0]    base_q;
	logic [31:0]   acc_q;
	logic          ovf_q;
	logic          anyd_q;
	logic [PW-1:0] pos_q;

	logic [2:0]    ph;
	logic          neg;
	logic [5:0]    base;
	logic [31:0]   acc;
	logic          ovf;
	logic          anyd;
	logic [PW-1:0] pos;
	logic          nstart;
	logic          dstep;
	logic          emit;
	logic [6:0]    dig;
	logic [38:0]   prod;
	logic [38:0]   lim;
	logic [31:0]   mag;

	logic          out_valid_q;
	logic          adv;
	logic          in_xfer;

	assign adv      = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;
	assign dig      = digit_of(ch_s1);

	always_comb begin
		ph     = phase_q;
		neg    = neg_q;
		base   = base_q;
		acc    = acc_q;
		ovf    = ovf_q;
		anyd   = anyd_q;
		pos    = pos_q;
		nstart = 1'b0;
		dstep  = 1'b0;
		emit   = 1'b0;
		prod   = '0;
		lim    = '0;
		if (start_s1) begin
			ph   = PH_SKIP;
			neg  = 1'b0;
			base = base_cfg_q;
			acc  = '0;
			ovf  = 1'b0;
			anyd = 1'b0;
			pos  = '0;
		end else if (phase_q != PH_IDLE && pos_q < PW'(POSITION_LIMIT)) begin
			pos = pos_q + 1'b1;
		end
		if (valid_s1 && (start_s1 || phase_q != PH_IDLE)) begin
			case (ph)
				PH_SKIP: begin
					if (is_space(ch_s1)) begin
						ph = PH_SKIP;
					end else if (ch_s1 == CH_MINUS) begin
						neg = 1'b1;
						ph  = PH_SIGNED;
					end else if (ch_s1 == CH_PLUS) begin
						ph = PH_SIGNED;
					end else begin
						nstart = 1'b1;
					end
				end
				PH_SIGNED: nstart = 1'b1;
				PH_ZERO: begin
					if (ch_s1 == CH_LX || ch_s1 == CH_UX) begin
						base = BASE_HEX;
						ph   = PH_HEXPFX;
					end else begin
						// the leading zero counts as a digit; accumulator stays zero
						if (base == BASE_AUTO)
							base = BASE_OCT;
						anyd  = 1'b1;
						dstep = 1'b1;
					end
				end
				PH_HEXPFX, PH_DIGITS: dstep = 1'b1;
				default: ph = PH_IDLE;
			endcase
			if (nstart) begin
				if ((base == BASE_AUTO || base == BASE_HEX) && ch_s1 == CH_ZERO) begin
					ph = PH_ZERO;
				end else begin
					if (base == BASE_AUTO)
						base = BASE_DEC;
					dstep = 1'b1;
				end
			end
			if (dstep) begin
				if (dig >= {1'b0, base}) begin
					emit = 1'b1;
					ph   = PH_IDLE;
				end else begin
					anyd = 1'b1;
					ph   = PH_DIGITS;
					if (!ovf) begin
						lim  = neg ? 39'(MAG_NEG_LIMIT) : 39'(MAG_POS_LIMIT);
						prod = 39'(acc) * 39'(base) + 39'(dig);
						if (prod > lim) begin
							ovf = 1'b1;
							acc = lim[31:0];
						end else begin
							acc = prod[31:0];
						end
					end
				end
			end
		end
		mag = anyd ? acc : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cfg_q <= BASE_AUTO;
		end else if (cfg_we) begin
			base_cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_s1    <= ch;
			start_s1 <= start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			anyd_q  <= 1'b0;
			pos_q   <= '0;
		end else if (adv) begin
			phase_q <= ph;
			neg_q   <= neg;
			base_q  <= base;
			acc_q   <= acc;
			ovf_q   <= ovf;
			anyd_q  <= anyd;
			pos_q   <= pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			value       <= neg ? $signed(32'd0 - mag) : $signed(mag);
			range_error <= ovf;
			converted   <= anyd;
			end_offset  <= anyd ? 16'(pos) : 16'd0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/t2i_checker.sv -----
module t2i_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] value,
	input logic               range_error,
	input logic               converted,
	input logic [15:0]        end_offset
);
	import t2i_pkg::*;

	// an overflow always reports a clamped value and at least one digit
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |->
			converted && ($unsigned(value) == MAG_POS_LIMIT ||
			$unsigned(value) == MAG_NEG_LIMIT))
		else $error("overflow result not clamped");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !converted |-> value == 32'sd0 && end_offset == 16'd0 && !range_error)
		else $error("result without digits not cleared");

	// a digit and its terminator take at least offset one
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && converted |-> end_offset != 16'd0)
		else $error("converted result with zero end offset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(end_offset))
		else $error("stalled result changed");

endmodule

bind text_to_int32_parser_core t2i_checker u_t2i_checker (.*);
